// ----- src/first_fit_extent_allocator_unit_macros.svh -----
// Assertion macros shared by the extent allocator RTL.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FFEA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define FFEA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FFEA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FFEA_ASSERT(label, clk, rst, prop, msg)
`define FFEA_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define FFEA_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- src/ffea_pkg.sv -----
// Package: sizes, codes and interface types of the extent allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffea_pkg;

   localparam int NUM_ENTRIES  = 64;
   localparam int ENTRY_IDX_W  = $clog2(NUM_ENTRIES);
   localparam int SECTOR_BYTES = 512;
   localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

   localparam int OP_W    = 2;
   localparam int IDX_W   = 6;
   localparam int SECT_W  = 16;
   localparam int LEN_W   = 24;
   localparam int STS_W   = 2;
   localparam int NEED_W  = LEN_W - SECTOR_SHIFT + 1;
   localparam int CAND_W  = SECT_W + 1;
   localparam int LIM_W   = SECT_W + 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
   localparam logic [OP_W-1:0] OP_RESIZE = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

   localparam logic [STS_W-1:0] STS_OK      = 2'd0;
   localparam logic [STS_W-1:0] STS_INVALID = 2'd1;
   localparam logic [STS_W-1:0] STS_NO_RUN  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_FIRST = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_END   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BYTES    = 2'd2;

   localparam logic [SECT_W-1:0] REGION_FIRST_RESET = 16'd4096;
   localparam logic [SECT_W-1:0] REGION_END_RESET   = 16'd32768;
   localparam logic [LEN_W-1:0]  MAX_BYTES_RESET    = 24'd1048576;

   typedef struct packed {
      logic init;
      logic eval;
      logic clr_hit;
   } fit_ctl_type;

   typedef struct packed {
      logic              fail;
      logic              hit;
      logic [SECT_W-1:0] run_start;
   } fit_sts_type;

endpackage
`default_nettype wire

// ----- src/ffea_table.sv -----
// Extent table: start/count memory with per-entry valid flops.
`timescale 1ns / 1ps
`default_nettype none
module ffea_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ffea_pkg::ENTRY_IDX_W-1:0]  rd_addr,
   output logic                              rd_valid,
   output logic [ffea_pkg::SECT_W-1:0]       rd_start,
   output logic [ffea_pkg::SECT_W-1:0]       rd_count,
   input  logic                              wr_en,
   input  logic [ffea_pkg::ENTRY_IDX_W-1:0]  wr_addr,
   input  logic                              wr_valid,
   input  logic [ffea_pkg::SECT_W-1:0]       wr_start,
   input  logic [ffea_pkg::SECT_W-1:0]       wr_count
);
   import ffea_pkg::*;

   logic [NUM_ENTRIES-1:0]  valid_ff;
   logic [2*SECT_W-1:0]     mem_ff [NUM_ENTRIES];
   logic [2*SECT_W-1:0]     rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= wr_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= {wr_start, wr_count};
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // invalid entries read as empty
   assign rd_valid = rd_valid_ff;
   assign rd_start = rd_valid_ff ? rd_data_ff[2*SECT_W-1:SECT_W] : '0;
   assign rd_count = rd_valid_ff ? rd_data_ff[SECT_W-1:0] : '0;

endmodule
`default_nettype wire

// ----- src/ffea_fit_unit.sv -----
// First-fit candidate unit: one overlap test and candidate bump per entry.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_extent_allocator_unit_macros.svh"
module ffea_fit_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  ffea_pkg::fit_ctl_type        ctl,
   input  logic [ffea_pkg::SECT_W-1:0]  region_first,
   input  logic [ffea_pkg::SECT_W-1:0]  region_end,
   input  logic [ffea_pkg::NEED_W-1:0]  need,
   input  logic [ffea_pkg::SECT_W-1:0]  ent_start,
   input  logic [ffea_pkg::SECT_W-1:0]  ent_count,
   output ffea_pkg::fit_sts_type        sts
);
   import ffea_pkg::*;

   logic [CAND_W-1:0] cand_ff, cand_in;
   logic [LIM_W-1:0]  lim_ff, lim_in;
   logic              hit_ff, hit_in;
   logic [CAND_W-1:0] ent_end;
   logic [CAND_W-1:0] base;
   logic [LIM_W-1:0]  sum;
   logic              overlap;

   assign ent_end = CAND_W'(ent_start) + CAND_W'(ent_count);
   assign overlap = (LIM_W'(ent_start) < lim_ff) && (ent_end > cand_ff);
   assign base    = ctl.init ? CAND_W'(region_first) : ent_end;
   assign sum     = LIM_W'(base) + LIM_W'(need);

   always_comb begin
      cand_in = cand_ff;
      lim_in  = lim_ff;
      hit_in  = hit_ff;
      if (ctl.init) begin
         cand_in = base;
         lim_in  = sum;
         hit_in  = 1'b0;
      end else begin
         if (ctl.clr_hit) begin
            hit_in = 1'b0;
         end
         // skip the candidate past the blocking extent
         if (ctl.eval && overlap) begin
            cand_in = ent_end;
            lim_in  = sum;
            hit_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      lim_ff  <= lim_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign sts.fail      = lim_ff > LIM_W'(region_end);
   assign sts.hit       = hit_ff;
   assign sts.run_start = cand_ff[SECT_W-1:0];

   `FFEA_ASSERT_NXT(a_cand_monotonic, clock, reset, ctl.eval && !ctl.init, cand_ff >= $past(cand_ff), "fit candidate moved backward")
   `FFEA_ASSERT_NXT(a_hit_on_bump, clock, reset, ctl.eval && !ctl.init && overlap, hit_ff, "candidate bump not flagged")

endmodule
`default_nettype wire

// ----- src/first_fit_extent_allocator_unit.sv -----
// Top level: first-fit extent allocator with table, fit unit and sequencer.
//
//   channel   ports                         handshake
//   request   req_op .. req_byte_length     start high while busy low
//   response  rsp_status .. rsp_freed_*     rsp_valid, one cycle, no stall
//   config    csr_wr_en/index/wr_data       write on csr_wr_en, no wait
//
// Load, clear, no-op and any request on an invalid entry go from accept
// to the response strobe through a table read and a decide step; a resize
// that stays in place or drops to empty adds a commit step. A resize that
// must relocate runs a first-fit search: each sweep reads one table entry
// per cycle through the single fit unit, repeated until a sweep moves the
// candidate no further or the candidate no longer fits below the region
// end; at most NUM_ENTRIES sweeps. Reset is synchronous; it clears the
// sequencer, the valid flops and the config registers. The response side
// cannot stall, so busy drops as soon as the response register loads.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_extent_allocator_unit_macros.svh"
module first_fit_extent_allocator_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ffea_pkg::OP_W-1:0]       req_op,
   input  logic [ffea_pkg::IDX_W-1:0]      req_entry_index,
   input  logic [ffea_pkg::SECT_W-1:0]     req_load_start,
   input  logic [ffea_pkg::SECT_W-1:0]     req_load_sectors,
   input  logic [ffea_pkg::LEN_W-1:0]      req_byte_length,
   output logic                            rsp_valid,
   output logic [ffea_pkg::STS_W-1:0]      rsp_status,
   output logic [ffea_pkg::SECT_W-1:0]     rsp_extent_start,
   output logic [ffea_pkg::SECT_W-1:0]     rsp_extent_sectors,
   output logic [ffea_pkg::LEN_W-1:0]      rsp_stored_length,
   output logic                            rsp_moved,
   output logic [ffea_pkg::SECT_W-1:0]     rsp_freed_start,
   output logic [ffea_pkg::SECT_W-1:0]     rsp_freed_sectors,
   input  logic                            csr_wr_en,
   input  logic [ffea_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ffea_pkg::LEN_W-1:0]      csr_wr_data
);
   import ffea_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_FETCH  = 5'b00010,
      S_DECIDE = 5'b00100,
      S_SCAN   = 5'b01000,
      S_COMMIT = 5'b10000
   } state_type;

   // configuration registers
   logic [SECT_W-1:0] region_first_ff;
   logic [SECT_W-1:0] region_end_ff;
   logic [LEN_W-1:0]  max_bytes_ff;

   // sequencer and request context
   state_type              state_ff, state_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic [ENTRY_IDX_W-1:0] self_ff, self_in;
   logic                   in_range_ff, in_range_in;
   logic [SECT_W-1:0]      ld_start_ff, ld_start_in;
   logic [SECT_W-1:0]      ld_count_ff, ld_count_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [NEED_W-1:0]      need_ff, need_in;
   logic [SECT_W-1:0]      old_ff, old_in;
   logic [SECT_W-1:0]      cur_ff, cur_in;
   logic [SECT_W-1:0]      ns_ff, ns_in;
   logic                   ok_ff, ok_in;

   // sweep control
   logic [ENTRY_IDX_W:0]   issue_cnt_ff, issue_cnt_in;
   logic                   pend_ff, pend_in;
   logic [ENTRY_IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic                   sweep_done;

   // response register
   logic                   rsp_valid_ff;
   logic [STS_W-1:0]       rsp_status_ff, r_status;
   logic [SECT_W-1:0]      rsp_start_ff, r_start;
   logic [SECT_W-1:0]      rsp_count_ff, r_count;
   logic [LEN_W-1:0]       rsp_len_ff, r_len;
   logic                   rsp_moved_ff, r_moved;
   logic [SECT_W-1:0]      rsp_fstart_ff, r_fstart;
   logic [SECT_W-1:0]      rsp_fcount_ff, r_fcount;
   logic                   resp_fire;

   // table and fit unit hookup
   logic [ENTRY_IDX_W-1:0] rd_addr;
   logic                   rd_valid;
   logic [SECT_W-1:0]      rd_start, rd_count;
   logic                   wr_en, wr_valid;
   logic [SECT_W-1:0]      wr_start, wr_count;
   fit_ctl_type            fit_ctl;
   fit_sts_type            fit_sts;

   logic                   accept;
   logic [LEN_W:0]         len_round;
   logic                   resize_moved;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // configuration writes; index 3 is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         region_first_ff <= REGION_FIRST_RESET;
         region_end_ff   <= REGION_END_RESET;
         max_bytes_ff    <= MAX_BYTES_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_REGION_FIRST: region_first_ff <= csr_wr_data[SECT_W-1:0];
            CSR_REGION_END:   region_end_ff   <= csr_wr_data[SECT_W-1:0];
            CSR_MAX_BYTES:    max_bytes_ff    <= csr_wr_data;
            default: ;
         endcase
      end
   end

   ffea_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_valid (rd_valid),
      .rd_start (rd_start),
      .rd_count (rd_count),
      .wr_en    (wr_en),
      .wr_addr  (self_ff),
      .wr_valid (wr_valid),
      .wr_start (wr_start),
      .wr_count (wr_count)
   );

   ffea_fit_unit u_fit (
      .clock        (clock),
      .reset        (reset),
      .ctl          (fit_ctl),
      .region_first (region_first_ff),
      .region_end   (region_end_ff),
      .need         (need_ff),
      .ent_start    (rd_start),
      .ent_count    (rd_count),
      .sts          (fit_sts)
   );

   // round the clamped length up to whole sectors
   assign len_round  = {1'b0, len_ff} + (LEN_W + 1)'(SECTOR_BYTES - 1);
   assign sweep_done = (issue_cnt_ff == (ENTRY_IDX_W + 1)'(NUM_ENTRIES)) && !pend_ff;

   // a relocation from a nonzero older start
   assign resize_moved = (need_ff != '0) && (old_ff != '0) && (old_ff != ns_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      self_in      = self_ff;
      in_range_in  = in_range_ff;
      ld_start_in  = ld_start_ff;
      ld_count_in  = ld_count_ff;
      len_in       = len_ff;
      need_in      = need_ff;
      old_in       = old_ff;
      cur_in       = cur_ff;
      ns_in        = ns_ff;
      ok_in        = ok_ff;
      issue_cnt_in = issue_cnt_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      rd_addr      = self_ff;
      wr_en        = 1'b0;
      wr_valid     = 1'b0;
      wr_start     = '0;
      wr_count     = '0;
      fit_ctl      = '0;
      resp_fire    = 1'b0;
      r_status     = STS_OK;
      r_start      = '0;
      r_count      = '0;
      r_len        = '0;
      r_moved      = 1'b0;
      r_fstart     = '0;
      r_fcount     = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_op;
               self_in     = ENTRY_IDX_W'(req_entry_index);
               in_range_in = int'(req_entry_index) < NUM_ENTRIES;
               ld_start_in = req_load_start;
               ld_count_in = req_load_sectors;
               // clamp to the byte limit up front
               len_in      = (req_byte_length > max_bytes_ff) ? max_bytes_ff
                                                              : req_byte_length;
               state_in    = S_FETCH;
            end
         end

         S_FETCH: begin
            // table read of the addressed entry is in flight
            need_in  = NEED_W'(len_round >> SECTOR_SHIFT);
            state_in = S_DECIDE;
         end

         S_DECIDE: begin
            old_in   = rd_start;
            cur_in   = rd_count;
            state_in = S_IDLE;
            if (!in_range_ff) begin
               resp_fire = 1'b1;
               r_status  = (op_ff == OP_NOP) ? STS_OK : STS_INVALID;
            end else begin
               case (op_ff)
                  OP_LOAD: begin
                     wr_en     = 1'b1;
                     wr_valid  = 1'b1;
                     wr_start  = ld_start_ff;
                     wr_count  = ld_count_ff;
                     resp_fire = 1'b1;
                     r_start   = ld_start_ff;
                     r_count   = ld_count_ff;
                  end
                  OP_NOP: begin
                     resp_fire = 1'b1;
                     r_start   = rd_start;
                     r_count   = rd_count;
                  end
                  default: begin
                     if (!rd_valid) begin
                        resp_fire = 1'b1;
                        r_status  = STS_INVALID;
                        r_start   = rd_start;
                        r_count   = rd_count;
                     end else if (op_ff == OP_CLEAR) begin
                        wr_en     = 1'b1;
                        resp_fire = 1'b1;
                        if ((rd_start != '0) && (rd_count != '0)) begin
                           r_fstart = rd_start;
                           r_fcount = rd_count;
                        end
                     end else if ((need_ff == '0) ||
                                  ((rd_start != '0) &&
                                   (LIM_W'(rd_count) >= LIM_W'(need_ff)))) begin
                        // shrink or keep in place, or drop to empty
                        ns_in    = (need_ff == '0) ? '0 : rd_start;
                        ok_in    = 1'b1;
                        state_in = S_COMMIT;
                     end else begin
                        // relocate: start a first-fit search
                        fit_ctl.init = 1'b1;
                        issue_cnt_in = '0;
                        state_in     = S_SCAN;
                     end
                  end
               endcase
            end
         end

         S_SCAN: begin
            fit_ctl.eval = pend_ff && (pend_idx_ff != self_ff) && rd_valid &&
                           (rd_count != '0);
            if (fit_sts.fail) begin
               ok_in    = 1'b0;
               state_in = S_COMMIT;
            end else if (sweep_done) begin
               if (fit_sts.hit) begin
                  // candidate moved this sweep: check every entry again
                  issue_cnt_in    = '0;
                  fit_ctl.clr_hit = 1'b1;
               end else begin
                  ok_in    = 1'b1;
                  ns_in    = fit_sts.run_start;
                  state_in = S_COMMIT;
               end
            end else if (issue_cnt_ff != (ENTRY_IDX_W + 1)'(NUM_ENTRIES)) begin
               rd_addr      = issue_cnt_ff[ENTRY_IDX_W-1:0];
               pend_in      = 1'b1;
               pend_idx_in  = issue_cnt_ff[ENTRY_IDX_W-1:0];
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
         end

         S_COMMIT: begin
            resp_fire = 1'b1;
            r_len     = len_ff;
            state_in  = S_IDLE;
            if (!ok_ff) begin
               r_status = STS_NO_RUN;
               r_start  = old_ff;
               r_count  = cur_ff;
            end else begin
               wr_en    = 1'b1;
               wr_valid = 1'b1;
               wr_start = ns_ff;
               wr_count = SECT_W'(need_ff);
               r_start  = ns_ff;
               r_count  = SECT_W'(need_ff);
               r_moved  = resize_moved;
               if (need_ff == '0) begin
                  if ((old_ff != '0) && (cur_ff != '0)) begin
                     r_fstart = old_ff;
                     r_fcount = cur_ff;
                  end
               end else if (resize_moved) begin
                  r_fstart = old_ff;
                  r_fcount = cur_ff;
               end else if ((LIM_W'(cur_ff) > LIM_W'(need_ff)) && (ns_ff != '0)) begin
                  // release the tail beyond the new size
                  r_fstart = SECT_W'(LIM_W'(ns_ff) + LIM_W'(need_ff));
                  r_fcount = SECT_W'(LIM_W'(cur_ff) - LIM_W'(need_ff));
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         issue_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         issue_cnt_ff <= issue_cnt_in;
         rsp_valid_ff <= resp_fire;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      self_ff     <= self_in;
      in_range_ff <= in_range_in;
      ld_start_ff <= ld_start_in;
      ld_count_ff <= ld_count_in;
      len_ff      <= len_in;
      need_ff     <= need_in;
      old_ff      <= old_in;
      cur_ff      <= cur_in;
      ns_ff       <= ns_in;
      ok_ff       <= ok_in;
      pend_idx_ff <= pend_idx_in;
      // hold the response fields until the next request completes
      if (resp_fire) begin
         rsp_status_ff <= r_status;
         rsp_start_ff  <= r_start;
         rsp_count_ff  <= r_count;
         rsp_len_ff    <= r_len;
         rsp_moved_ff  <= r_moved;
         rsp_fstart_ff <= r_fstart;
         rsp_fcount_ff <= r_fcount;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_extent_start   = rsp_start_ff;
   assign rsp_extent_sectors = rsp_count_ff;
   assign rsp_stored_length  = rsp_len_ff;
   assign rsp_moved          = rsp_moved_ff;
   assign rsp_freed_start    = rsp_fstart_ff;
   assign rsp_freed_sectors  = rsp_fcount_ff;

   `FFEA_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted request did not raise busy")
   `FFEA_ASSERT_NXT(a_fail_commit, clock, reset, (state_ff == S_SCAN) && fit_sts.fail, (state_ff == S_COMMIT) && !ok_ff, "failed search did not reach commit")
   `FFEA_ASSERT_NXT(a_single_strobe, clock, reset, rsp_valid_ff, !rsp_valid_ff, "response strobe held longer than one cycle")
   `FFEA_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid_ff, state_ff == S_IDLE, "response while sequencer active")
   `FFEA_ASSERT_IMP(a_issue_bound, clock, reset, state_ff == S_SCAN, issue_cnt_ff <= (ENTRY_IDX_W + 1)'(NUM_ENTRIES), "sweep counter overran the table")

endmodule
`default_nettype wire

// ----- bench/first_fit_extent_allocator_unit_tb.sv -----
// Self-checking bench: directed table and random requests against a first-fit extent predictor.
`timescale 1ns / 1ps
module first_fit_extent_allocator_unit_tb;
   import ffea_pkg::*;

   // Bound on the whole run. The slowest resize sweeps the table up to
   // NUM_ENTRIES times; the run sends ~100 requests with long gaps.
   localparam int LIMIT_CYCLES = 3_000_000;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [IDX_W-1:0]  entry_index;
      logic [SECT_W-1:0] load_start;
      logic [SECT_W-1:0] load_sectors;
      logic [LEN_W-1:0]  byte_length;
   } extent_req_t;

   typedef struct packed {
      logic [STS_W-1:0]  status;
      logic [SECT_W-1:0] extent_start;
      logic [SECT_W-1:0] extent_sectors;
      logic [LEN_W-1:0]  stored_length;
      logic              moved;
      logic [SECT_W-1:0] freed_start;
      logic [SECT_W-1:0] freed_sectors;
   } extent_rsp_t;

   // One directed row: the request, and a hand-written response where the
   // answer is obvious (typed set); otherwise the predictor decides.
   typedef struct packed {
      extent_req_t req;
      logic        typed;
      extent_rsp_t rsp;
   } stim_row_t;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [OP_W-1:0]      req_op;
   logic [IDX_W-1:0]     req_entry_index;
   logic [SECT_W-1:0]    req_load_start;
   logic [SECT_W-1:0]    req_load_sectors;
   logic [LEN_W-1:0]     req_byte_length;
   logic                 rsp_valid;
   logic [STS_W-1:0]     rsp_status;
   logic [SECT_W-1:0]    rsp_extent_start;
   logic [SECT_W-1:0]    rsp_extent_sectors;
   logic [LEN_W-1:0]     rsp_stored_length;
   logic                 rsp_moved;
   logic [SECT_W-1:0]    rsp_freed_start;
   logic [SECT_W-1:0]    rsp_freed_sectors;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LEN_W-1:0]     csr_wr_data;

   // Predictor copy of the extent table and the region registers.
   bit                ent_valid [NUM_ENTRIES];
   logic [SECT_W-1:0] ent_start [NUM_ENTRIES];
   logic [SECT_W-1:0] ent_count [NUM_ENTRIES];
   logic [SECT_W-1:0] cfg_first     = REGION_FIRST_RESET;
   logic [SECT_W-1:0] cfg_end       = REGION_END_RESET;
   logic [LEN_W-1:0]  cfg_max_bytes = MAX_BYTES_RESET;

   extent_rsp_t pending_extents [$];   // responses still owed by the block, oldest first
   stim_row_t   dir_tab [$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          idle_pct = 0;          // chance in percent of a gap after each request

   first_fit_extent_allocator_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_entry_index    (req_entry_index),
      .req_load_start     (req_load_start),
      .req_load_sectors   (req_load_sectors),
      .req_byte_length    (req_byte_length),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_extent_start   (rsp_extent_start),
      .rsp_extent_sectors (rsp_extent_sectors),
      .rsp_stored_length  (rsp_stored_length),
      .rsp_moved          (rsp_moved),
      .rsp_freed_start    (rsp_freed_start),
      .rsp_freed_sectors  (rsp_freed_sectors),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Lowest free run of need sectors inside the region, skipping entry self.
   // Jump the candidate past any extent that overlaps the window until the
   // window is clear or no longer fits below the region end.
   function automatic bit first_fit(input logic [31:0] need, input int self,
                                    output logic [31:0] found);
      logic [31:0] cand;
      logic [31:0] s;
      logic [31:0] e;
      bit          jumped;
      cand   = {16'd0, cfg_first};
      found  = '0;
      jumped = 1'b1;
      while (jumped) begin
         jumped = 1'b0;
         if (cand + need > {16'd0, cfg_end})
            return 1'b0;
         for (int j = 0; j < NUM_ENTRIES; j++) begin
            s = {16'd0, ent_start[j]};
            e = s + {16'd0, ent_count[j]};
            if (j != self && ent_valid[j] && ent_count[j] != '0 &&
                s < cand + need && e > cand) begin
               cand   = e;
               jumped = 1'b1;
            end
         end
      end
      found = cand;
      return 1'b1;
   endfunction

   // Apply one request to the table copy and return the response it owes.
   function automatic extent_rsp_t predict_extent(input extent_req_t q);
      extent_rsp_t r;
      logic [31:0] old_start;
      logic [31:0] old_count;
      logic [31:0] len;
      logic [31:0] need;
      logic [31:0] new_start;
      logic [31:0] got;
      bit          fits;
      int          i;
      r    = '0;
      i    = int'(q.entry_index);
      fits = 1'b1;
      if (q.op == OP_LOAD) begin
         ent_valid[i] = 1'b1;
         ent_start[i] = q.load_start;
         ent_count[i] = q.load_sectors;
      end else if (q.op != OP_NOP) begin
         if (!ent_valid[i]) begin
            r.status = STS_INVALID;
         end else if (q.op == OP_CLEAR) begin
            if (ent_start[i] != '0 && ent_count[i] != '0) begin
               r.freed_start   = ent_start[i];
               r.freed_sectors = ent_count[i];
            end
            ent_valid[i] = 1'b0;
            ent_start[i] = '0;
            ent_count[i] = '0;
         end else begin
            old_start = {16'd0, ent_start[i]};
            old_count = {16'd0, ent_count[i]};
            len = {8'd0, q.byte_length};
            if (len > {8'd0, cfg_max_bytes})
               len = {8'd0, cfg_max_bytes};
            r.stored_length = len[LEN_W-1:0];
            need = (len + 32'(SECTOR_BYTES - 1)) / 32'(SECTOR_BYTES);
            new_start = old_start;
            if (need == 0) begin
               new_start = '0;
            end else if (old_start == 0 || old_count < need) begin
               if (first_fit(need, i, got)) begin
                  new_start = got;
                  r.moved   = (old_start != 0 && old_start != got);
               end else begin
                  fits = 1'b0;
               end
            end
            if (!fits) begin
               r.status = STS_NO_RUN;
            end else begin
               ent_start[i] = new_start[SECT_W-1:0];
               ent_count[i] = need[SECT_W-1:0];
               if (need == 0) begin
                  if (old_start != 0 && old_count != 0) begin
                     r.freed_start   = old_start[SECT_W-1:0];
                     r.freed_sectors = old_count[SECT_W-1:0];
                  end
               end else if (r.moved) begin
                  r.freed_start   = old_start[SECT_W-1:0];
                  r.freed_sectors = old_count[SECT_W-1:0];
               end else if (old_count > need && new_start != 0) begin
                  // shrink in place: release the tail, start wraps at 16 bits
                  r.freed_start   = 16'(new_start + need);
                  r.freed_sectors = 16'(old_count - need);
               end
            end
         end
      end
      r.extent_start   = ent_start[i];
      r.extent_sectors = ent_count[i];
      return r;
   endfunction

   function automatic stim_row_t tab_row(input logic [OP_W-1:0] op, input int idx,
                                         input int ls, input int lc, input int len,
                                         input bit typed, input logic [STS_W-1:0] sts,
                                         input int es, input int ec, input int sl);
      stim_row_t r;
      r = '0;
      r.req.op                = op;
      r.req.entry_index       = 6'(idx);
      r.req.load_start        = 16'(ls);
      r.req.load_sectors      = 16'(lc);
      r.req.byte_length       = 24'(len);
      r.typed                 = typed;
      r.rsp.status            = sts;
      r.rsp.extent_start      = 16'(es);
      r.rsp.extent_sectors    = 16'(ec);
      r.rsp.stored_length     = 24'(sl);
      return r;
   endfunction

   // Present one request, hold it until accepted, then log what it owes.
   // Afterwards either keep start high for the next request or idle a while.
   task automatic send_request(input extent_req_t q, input bit typed, input extent_rsp_t want);
      extent_rsp_t calc;
      int          gap;
      int          pick;
      bit          settle;
      start            <= 1'b1;
      req_op           <= q.op;
      req_entry_index  <= q.entry_index;
      req_load_start   <= q.load_start;
      req_load_sectors <= q.load_sectors;
      req_byte_length  <= q.byte_length;
      do @(posedge clock); while (busy);
      calc = predict_extent(q);
      pending_extents.push_back(typed ? want : calc);
      gap    = 0;
      settle = 1'b0;
      if ($urandom_range(0, 99) < idle_pct) begin
         pick = $urandom_range(0, 19);
         if (pick < 16)
            gap = $urandom_range(1, 3);
         else if (pick < 19)
            gap = $urandom_range(8, 40);
         else begin
            gap    = 1;
            settle = 1'b1;
         end
      end
      if (gap != 0) begin
         start <= 1'b0;
         // hold off until every outstanding response is back
         if (settle)
            while (pending_extents.size() != 0) @(posedge clock);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop start and let the block go idle before touching the registers.
   task automatic drain_pending();
      start <= 1'b0;
      while (pending_extents.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all three registers back to back; region values carry junk in
   // the upper byte, which the block must drop.
   task automatic program_csrs(input logic [SECT_W-1:0] first, input logic [SECT_W-1:0] last,
                               input logic [LEN_W-1:0] max_bytes);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_REGION_FIRST;
      csr_wr_data <= {8'($urandom), first};
      @(posedge clock);
      cfg_first   = first;
      csr_index   <= CSR_REGION_END;
      csr_wr_data <= {8'($urandom), last};
      @(posedge clock);
      cfg_end     = last;
      csr_index   <= CSR_MAX_BYTES;
      csr_wr_data <= max_bytes;
      @(posedge clock);
      cfg_max_bytes = max_bytes;
      csr_wr_en   <= 1'b0;
   endtask

   // Random requests: mostly resizes on a handful of live entries so the
   // search sees contention; half of the loads keep small extents near the region start.
   task automatic run_random(input int n, input int pct);
      extent_req_t q;
      int          sel;
      int          mode;
      idle_pct = pct;
      repeat (n) begin
         q = {$urandom, $urandom};
         if ($urandom_range(0, 4) != 0)
            q.entry_index = 6'($urandom_range(0, 15));
         sel = $urandom_range(0, 99);
         if (sel < 15) begin
            q.op = OP_LOAD;
            mode = $urandom_range(0, 3);
            if (mode == 1) begin
               q.load_start   = '0;
               q.load_sectors = '0;
            end else if (mode >= 2) begin
               q.load_start   = 16'(cfg_first + 16'($urandom_range(0, 2000)));
               q.load_sectors = 16'($urandom_range(1, 48));
            end
         end else if (sel < 27) begin
            q.op = OP_CLEAR;
         end else if (sel < 32) begin
            q.op = OP_NOP;
         end else begin
            q.op = OP_RESIZE;
            mode = $urandom_range(0, 9);
            if (mode == 0)
               q.byte_length = '0;
            else if (mode == 2)
               q.byte_length = 24'(cfg_max_bytes + 24'($urandom_range(0, 600)));
            else if (mode > 2)
               q.byte_length = 24'($urandom_range(1, 48 * SECTOR_BYTES));
         end
         send_request(q, 1'b0, '0);
      end
      drain_pending();
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Every strobe must match the oldest outstanding request.
   always @(posedge clock) begin : watch_responses
      extent_rsp_t want;
      if (!reset && rsp_valid) begin
         if (pending_extents.size() == 0) begin
            $error("rsp_valid with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_extents.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("extent_start", 32'(want.extent_start), 32'(rsp_extent_start));
            check_field("extent_sectors", 32'(want.extent_sectors), 32'(rsp_extent_sectors));
            check_field("stored_length", 32'(want.stored_length), 32'(rsp_stored_length));
            check_field("moved", 32'(want.moved), 32'(rsp_moved));
            check_field("freed_start", 32'(want.freed_start), 32'(rsp_freed_start));
            check_field("freed_sectors", 32'(want.freed_sectors), 32'(rsp_freed_sectors));
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("first_fit_extent_allocator_unit_tb: done, errors");
         $finish;
      end
   end

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_op           <= OP_LOAD;
      req_entry_index  <= '0;
      req_load_start   <= '0;
      req_load_sectors <= '0;
      req_byte_length  <= '0;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_REGION_FIRST;
      csr_wr_data      <= '0;
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         ent_valid[k] = 1'b0;
         ent_start[k] = '0;
         ent_count[k] = '0;
      end

      // Directed requests on the reset region 4096..32767, 1 MiB limit.
      // untouched entries after reset
      dir_tab.push_back(tab_row(OP_CLEAR, 0, 0, 0, 0, 1'b1, STS_INVALID, 0, 0, 0));
      dir_tab.push_back(tab_row(OP_RESIZE, 63, 16'hFFFF, 16'hFFFF, 1000,
                                1'b1, STS_INVALID, 0, 0, 0));
      dir_tab.push_back(tab_row(OP_NOP, 5, 0, 0, 24'hFFFFFF, 1'b1, STS_OK, 0, 0, 0));
      // two neighbors at the region start and one entry with no start
      dir_tab.push_back(tab_row(OP_LOAD, 0, 4096, 8, 0, 1'b1, STS_OK, 4096, 8, 0));
      dir_tab.push_back(tab_row(OP_LOAD, 1, 4104, 4, 0, 1'b1, STS_OK, 4104, 4, 0));
      dir_tab.push_back(tab_row(OP_LOAD, 2, 0, 0, 0, 1'b1, STS_OK, 0, 0, 0));
      // first fit lands past both neighbors
      dir_tab.push_back(tab_row(OP_RESIZE, 2, 0, 0, 1, 1'b0, STS_OK, 0, 0, 0));
      // exact fit, shrink in place, then grow and relocate
      dir_tab.push_back(tab_row(OP_RESIZE, 0, 0, 0, 4096, 1'b0, STS_OK, 0, 0, 0));
      dir_tab.push_back(tab_row(OP_RESIZE, 0, 0, 0, 2048, 1'b0, STS_OK, 0, 0, 0));
      dir_tab.push_back(tab_row(OP_RESIZE, 0, 0, 0, 8192, 1'b0, STS_OK, 0, 0, 0));
      // length beyond the limit is clamped, then resize to nothing
      dir_tab.push_back(tab_row(OP_RESIZE, 1, 0, 0, 24'hFFFFFF, 1'b0, STS_OK, 0, 0, 0));
      dir_tab.push_back(tab_row(OP_RESIZE, 1, 0, 0, 0, 1'b0, STS_OK, 0, 0, 0));
      // extent at the top of the sector space: tail start wraps on shrink
      dir_tab.push_back(tab_row(OP_LOAD, 63, 16'hFFFF, 16'hFFFF, 0,
                                1'b1, STS_OK, 16'hFFFF, 16'hFFFF, 0));
      dir_tab.push_back(tab_row(OP_RESIZE, 63, 0, 0, 512, 1'b0, STS_OK, 0, 0, 0));
      dir_tab.push_back(tab_row(OP_CLEAR, 63, 0, 0, 0, 1'b0, STS_OK, 0, 0, 0));
      dir_tab.push_back(tab_row(OP_CLEAR, 2, 0, 0, 0, 1'b0, STS_OK, 0, 0, 0));
      dir_tab.push_back(tab_row(OP_NOP, 0, 0, 0, 0, 1'b0, STS_OK, 0, 0, 0));
      // one entry covers the whole region: no room for anyone else
      dir_tab.push_back(tab_row(OP_LOAD, 10, 4096, 28672, 0, 1'b1, STS_OK, 4096, 28672, 0));
      dir_tab.push_back(tab_row(OP_LOAD, 11, 0, 0, 0, 1'b1, STS_OK, 0, 0, 0));
      dir_tab.push_back(tab_row(OP_RESIZE, 11, 0, 0, 512, 1'b1, STS_NO_RUN, 0, 0, 512));
      dir_tab.push_back(tab_row(OP_RESIZE, 10, 0, 0, 24'hFFFFFF, 1'b0, STS_OK, 0, 0, 0));
      dir_tab.push_back(tab_row(OP_CLEAR, 10, 0, 0, 0, 1'b0, STS_OK, 0, 0, 0));
      // clear of a valid entry with nothing allocated, then of a dead one
      dir_tab.push_back(tab_row(OP_CLEAR, 11, 0, 0, 0, 1'b0, STS_OK, 0, 0, 0));
      dir_tab.push_back(tab_row(OP_CLEAR, 11, 0, 0, 0, 1'b1, STS_INVALID, 0, 0, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct = 30;
      foreach (dir_tab[k])
         send_request(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].rsp);

      // random phases; each drains before the registers change
      run_random(10, 30);
      program_csrs(16'd100, 16'd1124, 24'd32768);      // small region, back to back
      run_random(20, 0);
      program_csrs(16'd0, 16'hFFFF, 24'hFFFFFF);        // widest region and limit
      run_random(20, 40);
      program_csrs(16'hFFFF, 16'd0, 24'd1048576);       // inverted region
      run_random(6, 40);
      program_csrs(16'd4096, 16'd8192, 24'd0);          // zero limit: every resize empties
      run_random(6, 40);
      program_csrs(16'd200, 16'd600, 24'd20000);
      run_random(14, 25);

      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("first_fit_extent_allocator_unit_tb: done, clean");
      else
         $display("first_fit_extent_allocator_unit_tb: done, errors");
      $finish;
   end

endmodule
